// ----- sv/nd_slice_address_generator_macros.svh -----
// assertion macros shared by the slice address generator checkers
`ifndef ND_SLICE_ADDRESS_GENERATOR_MACROS_SVH
`define ND_SLICE_ADDRESS_GENERATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define NDSAG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define NDSAG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ndsag_pkg.sv -----
// types and codes shared by the slice address generator
package ndsag_pkg;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_INIT  = 2'd1;
	localparam logic [1:0] FUNC_FETCH = 2'd2;

	typedef enum logic [1:0] {
		ST_OK,
		ST_INVALID,
		ST_EXHAUSTED
	} status_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  dim_index;
		logic [15:0] extent;
		logic [15:0] slice_start;
		logic [15:0] slice_end;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] element_address;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [3:0]  num_dims;
		logic [31:0] base_address;
		logic        clear_run;
	} cfg_t;

endpackage

// ----- sv/ndsag_macc.sv -----
// shared multiply-accumulate unit: one chunk of the wide operand times the narrow one
module ndsag_macc #(
	parameter int ADDR_BITS   = 32,
	parameter int NARROW_BITS = 17
) (
	input  logic [ADDR_BITS-1:0]   wide,
	input  logic [NARROW_BITS-1:0] narrow,
	input  logic                   chunk_sel,
	input  logic [ADDR_BITS-1:0]   addend,
	output logic [ADDR_BITS-1:0]   sum
);

	localparam int MUL_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int PW    = MUL_W + NARROW_BITS;

	logic [2*MUL_W-1:0]  padded;
	logic [MUL_W-1:0]    chunk;
	logic [PW-1:0]       prod;
	logic [PW+MUL_W-1:0] placed;

	always_comb begin
		padded = (2*MUL_W)'(wide);
		chunk  = chunk_sel ? padded[2*MUL_W-1:MUL_W] : padded[MUL_W-1:0];
		prod   = PW'(chunk) * PW'(narrow);
		placed = chunk_sel ? {prod, {MUL_W{1'b0}}} : {{MUL_W{1'b0}}, prod};
		sum    = addend + ADDR_BITS'(placed);
	end

endmodule

// ----- sv/ndsag_engine.sv -----
// descriptor storage, sequencer and result register of the slice address generator
module ndsag_engine import ndsag_pkg::*; #(
	parameter int MAX_DIMS   = 10,
	parameter int INDEX_BITS = 16,
	parameter int ADDR_BITS  = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int NW = INDEX_BITS + 1;
	localparam logic LAST_CHUNK = (ADDR_BITS > 32) ? 1'b1 : 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CHECK,
		S_STRIDE,
		S_SUM,
		S_WRAP,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [IW-1:0]         cnt_q;
	logic                  chunk_q;
	logic                  running_q;
	logic                  all_end_q;
	item_t                 item_q;
	logic [ADDR_BITS-1:0]  acc_q;
	logic [ADDR_BITS-1:0]  prod_q;
	logic [ADDR_BITS-1:0]  sum_q;
	result_t               res_q;
	result_t               result_q;
	logic                  result_valid_q;

	logic [INDEX_BITS-1:0] dim_extent_q   [MAX_DIMS];
	logic [INDEX_BITS-1:0] dim_start_q    [MAX_DIMS];
	logic [INDEX_BITS-1:0] dim_end_q      [MAX_DIMS];
	logic [ADDR_BITS-1:0]  dim_stride_q   [MAX_DIMS];
	logic [NW-1:0]         dim_position_q [MAX_DIMS];

	logic [INDEX_BITS-1:0] rd_ext, rd_start, rd_end;
	logic [ADDR_BITS-1:0]  rd_str;
	logic [NW-1:0]         rd_pos, new_pos, pos_wdata;
	logic                  carry, str_we, pos_we, n_valid, load_ok;
	logic [IW-1:0]         last_idx;
	logic [ADDR_BITS-1:0]  m_wide, m_add, m_sum;
	logic [NW-1:0]         m_narrow;
	logic [3:0]            nd_minus1;

	ndsag_macc #(
		.ADDR_BITS  (ADDR_BITS),
		.NARROW_BITS(NW)
	) u_macc (
		.wide     (m_wide),
		.narrow   (m_narrow),
		.chunk_sel(chunk_q),
		.addend   (m_add),
		.sum      (m_sum)
	);

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		rd_ext    = dim_extent_q[cnt_q];
		rd_start  = dim_start_q[cnt_q];
		rd_end    = dim_end_q[cnt_q];
		rd_str    = dim_stride_q[cnt_q];
		rd_pos    = dim_position_q[cnt_q];
		new_pos   = rd_pos + NW'(1);
		carry     = (cnt_q != '0) && (new_pos > {1'b0, rd_end});
		n_valid   = (cfg.num_dims != 4'd0) && ({1'b0, cfg.num_dims} <= 5'(MAX_DIMS));
		nd_minus1 = cfg.num_dims - 4'd1;
		last_idx  = IW'(nd_minus1);
		load_ok   = ({1'b0, item_q.dim_index} < 5'(MAX_DIMS));
		m_wide    = rd_str;
		m_narrow  = rd_pos;
		m_add     = sum_q;
		str_we    = 1'b0;
		pos_we    = 1'b0;
		pos_wdata = {1'b0, rd_start};
		case (state_q)
			S_STRIDE: begin
				m_wide   = acc_q;
				m_narrow = {1'b0, rd_ext} + NW'(1);
				m_add    = chunk_q ? prod_q : '0;
				str_we   = !chunk_q;
				pos_we   = !chunk_q;
			end
			S_WRAP: begin
				pos_we    = !all_end_q;
				pos_wdata = carry ? {1'b0, rd_start} : new_pos;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (str_we)
			dim_stride_q[cnt_q] <= acc_q;
		if (pos_we)
			dim_position_q[cnt_q] <= pos_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			chunk_q        <= 1'b0;
			running_q      <= 1'b0;
			all_end_q      <= 1'b0;
			item_q         <= '0;
			acc_q          <= '0;
			prod_q         <= '0;
			sum_q          <= '0;
			res_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				dim_extent_q[i] <= '0;
				dim_start_q[i]  <= '0;
				dim_end_q[i]    <= '0;
			end
		end else begin
			if (result_valid_q && !result_stall && (state_q != S_DONE))
				result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						item_q  <= item;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (item_q.func)
						FUNC_LOAD: begin
							if (load_ok) begin
								dim_extent_q[item_q.dim_index[IW-1:0]] <=
									INDEX_BITS'(item_q.extent);
								dim_start_q[item_q.dim_index[IW-1:0]] <=
									INDEX_BITS'(item_q.slice_start);
								dim_end_q[item_q.dim_index[IW-1:0]] <=
									INDEX_BITS'(item_q.slice_end);
								running_q <= 1'b0;
							end
							res_q   <= '{status: ST_OK, element_address: '0, last: 1'b0};
							state_q <= S_DONE;
						end
						FUNC_INIT: begin
							if (!n_valid) begin
								running_q <= 1'b0;
								res_q     <= '{status: ST_INVALID, element_address: '0,
									last: 1'b0};
								state_q   <= S_DONE;
							end else begin
								cnt_q   <= '0;
								state_q <= S_CHECK;
							end
						end
						FUNC_FETCH: begin
							if (!running_q || !n_valid) begin
								res_q   <= '{status: ST_EXHAUSTED, element_address: '0,
									last: 1'b0};
								state_q <= S_DONE;
							end else begin
								cnt_q     <= '0;
								chunk_q   <= 1'b0;
								sum_q     <= ADDR_BITS'(cfg.base_address);
								all_end_q <= 1'b1;
								state_q   <= S_SUM;
							end
						end
						default: begin
							res_q   <= '{status: ST_INVALID, element_address: '0, last: 1'b0};
							state_q <= S_DONE;
						end
					endcase
				end
				S_CHECK: begin
					if ((rd_end > rd_ext) || (rd_start > rd_end)) begin
						running_q <= 1'b0;
						res_q     <= '{status: ST_INVALID, element_address: '0, last: 1'b0};
						state_q   <= S_DONE;
					end else if (cnt_q == last_idx) begin
						acc_q   <= ADDR_BITS'(1);
						chunk_q <= 1'b0;
						state_q <= S_STRIDE;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_STRIDE: begin
					prod_q <= m_sum;
					if (chunk_q == LAST_CHUNK) begin
						acc_q   <= m_sum;
						chunk_q <= 1'b0;
						if (cnt_q == '0) begin
							running_q <= 1'b1;
							res_q     <= '{status: ST_OK, element_address: '0, last: 1'b0};
							state_q   <= S_DONE;
						end else begin
							cnt_q <= cnt_q - IW'(1);
						end
					end else begin
						chunk_q <= 1'b1;
					end
				end
				S_SUM: begin
					sum_q <= m_sum;
					if (!chunk_q)
						all_end_q <= all_end_q && (rd_pos == {1'b0, rd_end});
					if (chunk_q == LAST_CHUNK) begin
						chunk_q <= 1'b0;
						if (cnt_q == last_idx)
							state_q <= S_WRAP;
						else
							cnt_q <= cnt_q + IW'(1);
					end else begin
						chunk_q <= 1'b1;
					end
				end
				S_WRAP: begin
					if (all_end_q) begin
						running_q <= 1'b0;
						res_q     <= '{status: ST_OK, element_address: 32'(sum_q), last: 1'b1};
						state_q   <= S_DONE;
					end else if (carry) begin
						cnt_q <= cnt_q - IW'(1);
					end else begin
						res_q   <= '{status: ST_OK, element_address: 32'(sum_q), last: 1'b0};
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_q       <= res_q;
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg.clear_run)
				running_q <= 1'b0;
		end
	end

endmodule

// ----- sv/nd_slice_address_generator.sv -----
// Row-major slice address generator for arrays of up to MAX_DIMS dimensions.
// One item is taken at a time; item_stall stays high from the accepting edge
// until the result beat enters the output register, and a finished result may
// wait there while the next item is taken. One shared multiplier forms one
// stride product (or one 32-bit chunk of it when ADDR_BITS exceeds 32) per
// cycle, and the index counters ripple their carry one dimension per cycle.
// Registers: num_dims at 0x0, base_address at 0x4.
module nd_slice_address_generator import ndsag_pkg::*; #(
	parameter int MAX_DIMS   = 10,
	parameter int INDEX_BITS = 16,
	parameter int ADDR_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  dim_index,
	input  logic [15:0] extent,
	input  logic [15:0] slice_start,
	input  logic [15:0] slice_end,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [31:0] element_address,
	output logic        last
);

	localparam logic REG_NUM_DIMS = 1'b0;
	localparam logic REG_BASE     = 1'b1;

	logic [3:0]  num_dims_q;
	logic [31:0] base_address_q;
	logic        wr_en;
	cfg_t        cfg;
	item_t       item;
	result_t     result;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_BASE) ? base_address_q : {28'd0, num_dims_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q     <= 4'd1;
			base_address_q <= '0;
		end else if (wr_en) begin
			if (paddr[2] == REG_NUM_DIMS)
				num_dims_q <= pwdata[3:0];
			else
				base_address_q <= pwdata;
		end
	end

	assign cfg = '{num_dims: num_dims_q, base_address: base_address_q,
		clear_run: wr_en && (paddr[2] == REG_NUM_DIMS)};
	assign item = '{func: func, dim_index: dim_index, extent: extent,
		slice_start: slice_start, slice_end: slice_end};

	ndsag_engine #(
		.MAX_DIMS  (MAX_DIMS),
		.INDEX_BITS(INDEX_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	assign status          = result.status;
	assign element_address = result.element_address;
	assign last            = result.last;

endmodule

// ----- sv/ndsag_checker.sv -----
// port-level checker for the slice address generator and its bind
`include "nd_slice_address_generator_macros.svh"

module ndsag_checker import ndsag_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  status,
	input logic [31:0] element_address,
	input logic        last
);

	`NDSAG_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(status) && $stable(element_address) && $stable(last), "stalled result beat changed")
	`NDSAG_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "engine took an item without going busy")
	`NDSAG_ASSERT_NOW(a_fail_is_clean, result_valid && (status != ST_OK), (element_address == 32'd0) && !last, "failed beat carries address or last")
	`NDSAG_ASSERT_NOW(a_last_is_ok, result_valid && last, status == ST_OK, "last flag on a failed beat")

endmodule

bind nd_slice_address_generator ndsag_checker u_ndsag_checker (.*);

// ----- tb/tb_nd_slice_address_generator.sv -----
// self-checking testbench for the row-major slice address generator
`timescale 1ns / 100ps

module tb_nd_slice_address_generator;
	import ndsag_pkg::*;

	localparam int DIM_SLOTS = 10;
	localparam logic [2:0] REG_NUM_DIMS = 3'h0;
	localparam logic [2:0] REG_BASE_ADDRESS = 3'h4;
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 25;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  func = '0;
	logic [3:0]  dim_index = '0;
	logic [15:0] extent = '0;
	logic [15:0] slice_start = '0;
	logic [15:0] slice_end = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] element_address;
	logic        last;

	nd_slice_address_generator dut (.*);

	// predictor copy of the generator state
	logic [3:0]  walk_dims;
	logic [31:0] walk_base;
	logic [15:0] axis_limit [DIM_SLOTS];
	logic [15:0] axis_first [DIM_SLOTS];
	logic [15:0] axis_final [DIM_SLOTS];
	logic [31:0] axis_stride [DIM_SLOTS];
	logic [16:0] axis_cursor [DIM_SLOTS];
	logic        walk_active;

	item_t   pending_items [$];
	result_t expected_beats [$];

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_requests = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int fail_count = 0;
	int items_taken = 0;
	int settings_applied = 0;
	int seen_ok = 0;
	int seen_last = 0;
	int seen_invalid = 0;
	int seen_exhausted = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic result_t compute_slice_beat(item_t it);
		result_t r;
		logic [31:0] acc;
		logic [31:0] sum;
		bit at_end;
		int d;
		r.status = ST_OK;
		r.element_address = '0;
		r.last = 1'b0;
		case (it.func)
			FUNC_LOAD: begin
				if (it.dim_index < DIM_SLOTS) begin
					axis_limit[it.dim_index] = it.extent;
					axis_first[it.dim_index] = it.slice_start;
					axis_final[it.dim_index] = it.slice_end;
					walk_active = 1'b0;
				end
			end
			FUNC_INIT: begin
				if (walk_dims == 0 || walk_dims > DIM_SLOTS) begin
					r.status = ST_INVALID;
				end else begin
					for (d = 0; d < walk_dims; d++) begin
						if (axis_final[d] > axis_limit[d] || axis_first[d] > axis_final[d])
							r.status = ST_INVALID;
					end
				end
				if (r.status == ST_INVALID) begin
					walk_active = 1'b0;
				end else begin
					acc = 32'd1;
					for (d = walk_dims - 1; d >= 0; d--) begin
						axis_stride[d] = acc;
						axis_cursor[d] = 17'(axis_first[d]);
						acc = acc * (32'(axis_limit[d]) + 32'd1);
					end
					walk_active = 1'b1;
				end
			end
			FUNC_FETCH: begin
				if (!walk_active || walk_dims == 0 || walk_dims > DIM_SLOTS) begin
					r.status = ST_EXHAUSTED;
				end else begin
					sum = walk_base;
					at_end = 1'b1;
					for (d = 0; d < walk_dims; d++) begin
						sum = sum + axis_stride[d] * axis_cursor[d];
						if (axis_cursor[d] != 17'(axis_final[d]))
							at_end = 1'b0;
					end
					r.element_address = sum;
					if (at_end) begin
						r.last = 1'b1;
						walk_active = 1'b0;
					end else begin
						// odometer step, last dimension fastest
						d = walk_dims - 1;
						axis_cursor[d]++;
						while (d > 0 && axis_cursor[d] > 17'(axis_final[d])) begin
							axis_cursor[d] = 17'(axis_first[d]);
							axis_cursor[d - 1]++;
							d--;
						end
					end
				end
			end
			default: r.status = ST_INVALID;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : drive_items
		bit taken;
		bit offer;
		taken = arst_n && item_valid && !item_stall;
		if (taken) begin
			expected_beats.push_back(compute_slice_beat(pending_items[0]));
			void'(pending_items.pop_front());
			items_taken++;
		end
		if (!item_valid || taken) begin
			offer = arst_n && pending_items.size() != 0
				&& $urandom_range(99, 0) >= sender_idle_pct;
			item_valid <= offer;
			if (offer) begin
				func <= pending_items[0].func;
				dim_index <= pending_items[0].dim_index;
				extent <= pending_items[0].extent;
				slice_start <= pending_items[0].slice_start;
				slice_end <= pending_items[0].slice_end;
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing outstanding: status %0d address %h",
					status, element_address);
				fail_count++;
			end else begin
				want = expected_beats.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (element_address !== want.element_address) begin
					$error("element_address: expected %h, actual %h",
						want.element_address, element_address);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					fail_count++;
				end
				case (status)
					ST_OK: seen_ok++;
					ST_INVALID: seen_invalid++;
					ST_EXHAUSTED: seen_exhausted++;
					default: ;
				endcase
				if (last === 1'b1)
					seen_last++;
			end
		end
		if (hold_taken != hold_requests) begin
			hold_taken = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_nd_slice_address_generator NOT OK");
		$finish;
	end

	task automatic queue_item(logic [1:0] f, logic [3:0] di, logic [15:0] ex,
			logic [15:0] st, logic [15:0] en);
		item_t it;
		it.func = f;
		it.dim_index = di;
		it.extent = ex;
		it.slice_start = st;
		it.slice_end = en;
		pending_items.push_back(it);
	endtask

	task automatic write_register(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (addr)
			REG_NUM_DIMS: begin
				walk_dims = data[3:0];
				walk_active = 1'b0;
			end
			REG_BASE_ADDRESS: walk_base = data;
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_config(logic [3:0] dims, logic [31:0] base);
		write_register(REG_NUM_DIMS, 32'(dims));
		write_register(REG_BASE_ADDRESS, base);
		settings_applied++;
	endtask

	task automatic wait_for_drain();
		do @(posedge clk); while (pending_items.size() != 0 || expected_beats.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// descriptors for every dimension, an init, then fetches that may stop short of or go past the end
	task automatic queue_slice_walk(int dims, inout int pushed);
		int budget, len, elements, fetches, bad_dim, d, k;
		bit reverse;
		logic [15:0] ex, st, en;
		budget = ($urandom_range(3, 0) == 0) ? 64 : 12;
		elements = 1;
		bad_dim = ($urandom_range(99, 0) < 12) ? $urandom_range(dims - 1, 0) : -1;
		reverse = $urandom_range(1, 0);
		for (k = 0; k < dims; k++) begin
			d = reverse ? dims - 1 - k : k;
			case ($urandom_range(3, 0))
				0: ex = 16'hffff;
				1: ex = 16'($urandom);
				default: ex = 16'($urandom_range(7, 0));
			endcase
			len = $urandom_range(budget < 4 ? budget : 4, 1);
			if (len > int'(ex) + 1)
				len = int'(ex) + 1;
			case ($urandom_range(3, 0))
				0: st = 16'd0;
				1: st = 16'(int'(ex) - len + 1);
				default: st = 16'($urandom_range(int'(ex) - len + 1, 0));
			endcase
			en = 16'(int'(st) + len - 1);
			elements *= len;
			budget /= len;
			if (d == bad_dim) begin
				if ($urandom_range(1, 0) && ex != 16'hffff)
					en = ex + 16'd1;
				else if (en != 16'hffff)
					st = en + 16'd1;
				else
					en = st - 16'd1;
			end
			queue_item(FUNC_LOAD, 4'(d), ex, st, en);
		end
		pushed += dims;
		// an unused or absent dimension must not matter
		if ($urandom_range(99, 0) < 20) begin
			queue_item(FUNC_LOAD, 4'($urandom_range(15, dims)), 16'($urandom),
				16'($urandom), 16'($urandom));
			pushed++;
		end
		queue_item(FUNC_INIT, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		pushed++;
		if (bad_dim >= 0)
			fetches = $urandom_range(2, 1);
		else if ($urandom_range(99, 0) < 10)
			fetches = $urandom_range(elements, 1);
		else
			fetches = elements + $urandom_range(2, 0);
		repeat (fetches)
			queue_item(FUNC_FETCH, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		pushed += fetches;
	endtask

	initial begin : stimulus
		int phase, sp, count, target, dims;
		walk_dims = 4'd1;
		walk_base = '0;
		walk_active = 1'b0;
		for (int d = 0; d < DIM_SLOTS; d++) begin
			axis_limit[d] = '0;
			axis_first[d] = '0;
			axis_final[d] = '0;
			axis_stride[d] = '0;
			axis_cursor[d] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: settings after reset
		queue_item(FUNC_FETCH, 4'd0, 16'd0, 16'd0, 16'd0);
		queue_item(FUNC_SPARE, 4'hf, 16'hffff, 16'hffff, 16'hffff);
		queue_item(FUNC_LOAD, 4'hf, 16'hffff, 16'h0000, 16'hffff);
		queue_item(FUNC_LOAD, 4'd10, 16'h1234, 16'h0000, 16'h0005);
		queue_item(FUNC_LOAD, 4'd0, 16'd0, 16'd0, 16'd0);
		queue_item(FUNC_INIT, 4'd0, 16'd0, 16'd0, 16'd0);
		repeat (2) queue_item(FUNC_FETCH, 4'd0, 16'd0, 16'd0, 16'd0);
		wait_for_drain();

		// directed: three dimensions, addresses wrapping past the top
		apply_config(4'd3, 32'hffff_fff0);
		queue_item(FUNC_LOAD, 4'd0, 16'd2, 16'd1, 16'd2);
		queue_item(FUNC_LOAD, 4'd1, 16'hffff, 16'hfffe, 16'hffff);
		queue_item(FUNC_LOAD, 4'd2, 16'd0, 16'd0, 16'd0);
		queue_item(FUNC_INIT, 4'd0, 16'd0, 16'd0, 16'd0);
		repeat (5) queue_item(FUNC_FETCH, 4'd0, 16'd0, 16'd0, 16'd0);
		// end above extent
		queue_item(FUNC_LOAD, 4'd2, 16'd5, 16'd3, 16'd6);
		queue_item(FUNC_INIT, 4'd0, 16'd0, 16'd0, 16'd0);
		// start above end
		queue_item(FUNC_LOAD, 4'd2, 16'd5, 16'd4, 16'd3);
		queue_item(FUNC_INIT, 4'd0, 16'd0, 16'd0, 16'd0);
		queue_item(FUNC_LOAD, 4'd2, 16'd5, 16'd5, 16'd5);
		queue_item(FUNC_INIT, 4'd0, 16'd0, 16'd0, 16'd0);
		queue_item(FUNC_FETCH, 4'd0, 16'd0, 16'd0, 16'd0);
		// load while running stops the walk
		queue_item(FUNC_LOAD, 4'd1, 16'hffff, 16'd0, 16'd0);
		queue_item(FUNC_FETCH, 4'd0, 16'd0, 16'd0, 16'd0);
		wait_for_drain();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
				1: begin sender_idle_pct = 80; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 80; end
				default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
			endcase
			for (sp = 0; sp < 5; sp++) begin
				case (sp)
					0: apply_config(4'd10, 32'hffff_ffff);
					1: apply_config(4'd1, 32'h0000_0000);
					2: apply_config(phase == 0 ? 4'd0 : phase == 1 ? 4'd15
						: 4'($urandom_range(15, 11)), $urandom);
					default: apply_config(4'($urandom_range(10, 1)), $urandom);
				endcase
				target = (sp == 2) ? 30 : 100;
				count = 0;
				while (count < target) begin
					if ($urandom_range(99, 0) < 15) begin
						queue_item(2'($urandom_range(3, 0)), 4'($urandom_range(15, 0)),
							16'($urandom), 16'($urandom), 16'($urandom));
						count++;
					end else begin
						dims = (walk_dims == 0 || walk_dims > DIM_SLOTS)
							? $urandom_range(DIM_SLOTS, 1) : int'(walk_dims);
						queue_slice_walk(dims, count);
					end
				end
				// long receiver hold so the block backs up into the sender
				if (phase == 0 && sp == 3)
					hold_requests++;
				wait_for_drain();
			end
		end

		$display("covered %0d items under %0d register settings, idle and stall mixes included",
			items_taken, settings_applied);
		$display("results: %0d ok with %0d final elements, %0d invalid, %0d exhausted",
			seen_ok, seen_last, seen_invalid, seen_exhausted);
		if (fail_count == 0 && expected_beats.size() == 0)
			$display("tb_nd_slice_address_generator OK");
		else
			$display("tb_nd_slice_address_generator NOT OK");
		$finish;
	end

endmodule
